// ----- rtl/sqicg_pkg.sv -----
// Package for the switch qualified item counter gate.
// Holds the qualifier phase type, drive mode codes, drive values and register indexes.
// Depends on nothing; used by switch_qualified_item_counter_gate_top.
package sqicg_pkg;

    // Qualifier phases as reported on the qualifier state output.
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_PRESSING  = 2'd1,
        PH_HOLDING   = 2'd2,
        PH_RELEASING = 2'd3
    } phase_t;

    // Drive mode codes carried by each input word.
    typedef enum logic [1:0] {
        MODE_INTAKE  = 2'd0,
        MODE_OFF     = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_FORCED  = 2'd3
    } drive_mode_t;

    // Motor command values.
    typedef logic signed [1:0] drive_t;
    localparam drive_t DRIVE_FWD  = 2'sd1;
    localparam drive_t DRIVE_STOP = 2'sd0;
    localparam drive_t DRIVE_REV  = -2'sd1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ITEM_CAPACITY = 2'd2;

    // Register widths and reset values.
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned CAPACITY_W = 8;
    localparam int unsigned COUNT_OUT_W = 8;
    localparam logic [TICKS_W-1:0]    PRESS_TICKS_RST   = 16'd10;
    localparam logic [TICKS_W-1:0]    RELEASE_TICKS_RST = 16'd10;
    localparam logic [CAPACITY_W-1:0] ITEM_CAPACITY_RST = 8'd5;

endpackage

// ----- rtl/switch_qualified_item_counter_gate_top.sv -----
// Top level of the switch qualified item counter gate.
// Qualifies limit-switch presses and releases, counts items and gates the drives.
// Depends on sqicg_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_switch_pressed, s_drive_mode, s_clear_count
//  m_      | out       | m_valid / m_ready  | m_intake_drive, m_feeder_drive, m_item_count,
//          |           |                    | m_qualifier_state
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One word per cycle while the result channel is not stalled; a result word passes from the
// input register to the result register through the state update.
// Reset (aresetn low, synchronous) empties both stages, sets the phase to idle, clears the
// timer and the count, and loads the register defaults (10, 10, 5).
// A stalled result holds the result register; the input register still takes one more word if it is empty.
module switch_qualified_item_counter_gate_top #(
    parameter int unsigned TIMER_WIDTH = 16,
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Input word channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_switch_pressed,
    input  logic [1:0]                              s_drive_mode,
    input  logic                                    s_clear_count,
    // Result word channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [1:0]                       m_intake_drive,
    output logic signed [1:0]                       m_feeder_drive,
    output logic [sqicg_pkg::COUNT_OUT_W-1:0]       m_item_count,
    output logic [1:0]                              m_qualifier_state,
    // Configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [sqicg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [sqicg_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int unsigned CMP_W = (TIMER_WIDTH > sqicg_pkg::TICKS_W) ?
                                    TIMER_WIDTH : sqicg_pkg::TICKS_W;
    localparam int unsigned CAP_CMP_W = (COUNT_WIDTH > sqicg_pkg::CAPACITY_W) ?
                                        COUNT_WIDTH : sqicg_pkg::CAPACITY_W;

    // Configuration registers
    logic [sqicg_pkg::TICKS_W-1:0]    press_ticks_reg;
    logic [sqicg_pkg::TICKS_W-1:0]    release_ticks_reg;
    logic [sqicg_pkg::CAPACITY_W-1:0] item_capacity_reg;

    // Input stage
    logic                             in_valid_reg;
    logic                             in_pressed_reg;
    sqicg_pkg::drive_mode_t           in_mode_reg;
    logic                             in_clear_reg;

    // Qualifier state
    sqicg_pkg::phase_t                phase_reg;
    sqicg_pkg::phase_t                phase_next;
    logic [TIMER_WIDTH-1:0]           timer_reg;
    logic [TIMER_WIDTH-1:0]           timer_next;
    logic [COUNT_WIDTH-1:0]           count_reg;
    logic [COUNT_WIDTH-1:0]           count_next;

    // Result stage
    logic                             out_valid_reg;
    sqicg_pkg::drive_t                intake_reg;
    sqicg_pkg::drive_t                feeder_reg;
    logic [sqicg_pkg::COUNT_OUT_W-1:0] item_count_reg;
    sqicg_pkg::phase_t                state_out_reg;

    // Combinational helpers
    logic                             advance;
    logic [TIMER_WIDTH-1:0]           timer_bumped;
    logic [COUNT_WIDTH-1:0]           count_base;
    logic [COUNT_WIDTH-1:0]           count_bumped;
    logic                             press_done;
    logic                             release_done;
    logic                             below_capacity;
    sqicg_pkg::drive_t                intake_next;
    sqicg_pkg::drive_t                feeder_next;

    // The input word moves on whenever the result register is free or being emptied.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_ticks_reg   <= sqicg_pkg::PRESS_TICKS_RST;
            release_ticks_reg <= sqicg_pkg::RELEASE_TICKS_RST;
            item_capacity_reg <= sqicg_pkg::ITEM_CAPACITY_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == sqicg_pkg::REG_PRESS_TICKS) begin
                press_ticks_reg <= cfg_wdata;
            end else if (cfg_index == sqicg_pkg::REG_RELEASE_TICKS) begin
                release_ticks_reg <= cfg_wdata;
            end else if (cfg_index == sqicg_pkg::REG_ITEM_CAPACITY) begin
                item_capacity_reg <= cfg_wdata[sqicg_pkg::CAPACITY_W-1:0];
            end
        end
    end

    // Saturating timer and count increments, and the threshold compares.
    always_comb begin
        timer_bumped   = (timer_reg == '1) ? timer_reg : timer_reg + 1'b1;
        count_base     = in_clear_reg ? '0 : count_reg;
        count_bumped   = (count_base == '1) ? count_base : count_base + 1'b1;
        press_done     = CMP_W'(timer_bumped) > CMP_W'(press_ticks_reg);
        release_done   = CMP_W'(timer_bumped) > CMP_W'(release_ticks_reg);
    end

    // Qualifier step; the clear acts before it.
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        count_next = count_base;
        unique case (phase_reg)
            sqicg_pkg::PH_IDLE: begin
                if (in_pressed_reg) begin
                    phase_next = sqicg_pkg::PH_PRESSING;
                    timer_next = '0;
                end
            end
            sqicg_pkg::PH_PRESSING: begin
                if (!in_pressed_reg) begin
                    phase_next = sqicg_pkg::PH_IDLE;
                end else begin
                    timer_next = timer_bumped;
                    if (press_done) begin
                        phase_next = sqicg_pkg::PH_HOLDING;
                    end
                end
            end
            sqicg_pkg::PH_HOLDING: begin
                if (!in_pressed_reg) begin
                    phase_next = sqicg_pkg::PH_RELEASING;
                    timer_next = '0;
                end
            end
            sqicg_pkg::PH_RELEASING: begin
                if (in_pressed_reg) begin
                    phase_next = sqicg_pkg::PH_HOLDING;
                end else begin
                    timer_next = timer_bumped;
                    if (release_done) begin
                        phase_next = sqicg_pkg::PH_IDLE;
                        count_next = count_bumped;
                    end
                end
            end
            default: begin
                phase_next = sqicg_pkg::PH_IDLE;
            end
        endcase
    end

    // Drive selection from the mode, the new phase and the new count.
    always_comb begin
        below_capacity = CAP_CMP_W'(count_next) < CAP_CMP_W'(item_capacity_reg);
        intake_next    = sqicg_pkg::DRIVE_FWD;
        feeder_next    = sqicg_pkg::DRIVE_FWD;
        unique case (in_mode_reg)
            sqicg_pkg::MODE_INTAKE: begin
                intake_next = sqicg_pkg::DRIVE_FWD;
                if (phase_next == sqicg_pkg::PH_HOLDING ||
                    phase_next == sqicg_pkg::PH_RELEASING) begin
                    feeder_next = below_capacity ? sqicg_pkg::DRIVE_FWD
                                                 : sqicg_pkg::DRIVE_STOP;
                end else begin
                    feeder_next = sqicg_pkg::DRIVE_FWD;
                end
            end
            sqicg_pkg::MODE_OFF: begin
                intake_next = sqicg_pkg::DRIVE_STOP;
                feeder_next = sqicg_pkg::DRIVE_STOP;
            end
            sqicg_pkg::MODE_REVERSE: begin
                intake_next = sqicg_pkg::DRIVE_REV;
                feeder_next = sqicg_pkg::DRIVE_REV;
            end
            sqicg_pkg::MODE_FORCED: begin
                intake_next = sqicg_pkg::DRIVE_FWD;
                feeder_next = sqicg_pkg::DRIVE_FWD;
            end
            default: begin
                intake_next = sqicg_pkg::DRIVE_STOP;
                feeder_next = sqicg_pkg::DRIVE_STOP;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_pressed_reg <= s_switch_pressed;
            in_mode_reg    <= sqicg_pkg::drive_mode_t'(s_drive_mode);
            in_clear_reg   <= s_clear_count;
        end
    end

    // Qualifier state and result register, both updated as a word moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= sqicg_pkg::PH_IDLE;
            timer_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                count_reg <= count_next;
            end
        end
        if (advance && in_valid_reg) begin
            intake_reg     <= intake_next;
            feeder_reg     <= feeder_next;
            item_count_reg <= sqicg_pkg::COUNT_OUT_W'(count_next);
            state_out_reg  <= phase_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_intake_drive    = intake_reg;
    assign m_feeder_drive    = feeder_reg;
    assign m_item_count      = item_count_reg;
    assign m_qualifier_state = state_out_reg;

`ifndef SYNTHESIS
    // The count only rises on a completed release.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg) && count_reg != '0) |->
        ($past(phase_reg) == sqicg_pkg::PH_RELEASING && phase_reg == sqicg_pkg::PH_IDLE))
        else $error("item count rose without a completed release");

    // Holding is never reached straight from idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == sqicg_pkg::PH_HOLDING) |-> ($past(phase_reg) != sqicg_pkg::PH_IDLE))
        else $error("qualifier jumped from idle to holding");

    // A stopped feeder with a running intake only happens while an item is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && feeder_reg == sqicg_pkg::DRIVE_STOP &&
         intake_reg == sqicg_pkg::DRIVE_FWD) |->
        (state_out_reg == sqicg_pkg::PH_HOLDING || state_out_reg == sqicg_pkg::PH_RELEASING))
        else $error("feeder stopped outside a held item");

    // A word in the input stage that cannot move on stays there.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage word lost during a stall");
`endif

endmodule
